// ===== design/assert_macros.svh =====
// Assertion macros shared by the design files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at each rising clock edge outside reset.
`define MCR_ASSERT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("muskingum_cascade_router: same-cycle check failed");

// Next-cycle implication, checked at each rising clock edge outside reset.
`define MCR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("muskingum_cascade_router: next-cycle check failed");

`endif

// ===== design/mcr_pkg.sv =====
// Shared constants and codes of the Muskingum cascade router.
`default_nettype none
package mcr_pkg;
  localparam int VOL_W = 32;
  localparam int STORE_W = 40;
  localparam int COEF_W = 18;
  // Fraction bits of the Q2.16 coefficients; tied to COEF_W.
  localparam int COEF_FRAC_BITS = 16;
  localparam int SUB_REG_W = 8;
  localparam int REACH_REG_W = 7;
  localparam int CFG_IDX_W = 3;
  // Upper part of the serial product accumulator, with margin over three terms.
  localparam int HI_W = 22;
  localparam int PROD_W = HI_W + VOL_W;
  localparam int BIT_CNT_W = $clog2(VOL_W);

  localparam logic [CFG_IDX_W-1:0] CFG_COEF_IN_NOW = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_IN_BEFORE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_OUT_BEFORE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SUBSTEP_COUNT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_REACH_COUNT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_BYPASS = 3'd5;
endpackage
`default_nettype wire

// ===== design/mcr_if.sv =====
// Valid/ready channel interfaces for inflow items and routing results.
`default_nettype none
interface mcr_in_if;
  logic valid;
  logic ready;
  logic [mcr_pkg::VOL_W-1:0] inflow_volume;
  modport source (output valid, output inflow_volume, input ready);
  modport sink (input valid, input inflow_volume, output ready);
endinterface

interface mcr_out_if;
  logic valid;
  logic ready;
  logic [mcr_pkg::VOL_W-1:0] outflow_volume;
  logic [mcr_pkg::STORE_W-1:0] total_storage;
  modport source (output valid, output outflow_volume, output total_storage, input ready);
  modport sink (input valid, input outflow_volume, input total_storage, output ready);
endinterface
`default_nettype wire

// ===== design/mcr_divider.sv =====
// Restoring divider that produces one quotient bit per cycle.
`default_nettype none
module mcr_divider #(
  parameter int DEN_W = 8
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [mcr_pkg::VOL_W-1:0] dividend,
  input  logic [DEN_W-1:0]          divisor,
  output logic                      done,
  output logic [mcr_pkg::VOL_W-1:0] quotient
);
  logic                           busy;
  logic [mcr_pkg::BIT_CNT_W-1:0]  cnt;
  logic [DEN_W-1:0]               rem;
  logic [DEN_W:0]                 trial;
  logic                           fits;
  logic                           last_bit;

  // Bring down the next dividend bit and try a subtraction.
  assign trial = {rem, quotient[mcr_pkg::VOL_W-1]};
  assign fits = trial >= {1'b0, divisor};
  assign last_bit = (cnt == mcr_pkg::BIT_CNT_W'(mcr_pkg::VOL_W - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt <= '0;
      rem <= '0;
      quotient <= dividend;
    end else if (busy) begin
      rem <= fits ? DEN_W'(trial - {1'b0, divisor}) : DEN_W'(trial);
      quotient <= {quotient[mcr_pkg::VOL_W-2:0], fits};
      cnt <= cnt + 1'b1;
      done <= last_bit;
      if (last_bit) begin
        busy <= 1'b0;
      end
    end else begin
      done <= 1'b0;
    end
  end

  `include "assert_macros.svh"
  `MCR_ASSERT(a_done_from_busy, done, !busy)
  `MCR_ASSERT_NEXT(a_start_busy, start, busy && !done)
  `MCR_ASSERT(a_done_remainder, done, rem < divisor)
endmodule
`default_nettype wire

// ===== design/muskingum_cascade_router.sv =====
// Muskingum cascade router: top level with control sequencer and reach stores.
//
// Each inflow item is divided by the substep count in a bit-serial divider, then every
// substep visits each sub-reach in turn. One sub-reach visit consists of the store
// read, the bit-serial weighted sum of the three coefficient products, rounding and
// clamping and the write-back. After the last substep the storages are summed one
// sub-reach at a time. With bypass set the inflow is passed straight to the result.
// A result held back by the receiver stalls the next item. Storage and previous-value
// stores need no clearing pass after reset: per-entry valid bits mark entries that
// read as zero.
`default_nettype none
module muskingum_cascade_router #(
  parameter int MAX_REACHES = 64,
  parameter int MAX_SUBSTEPS = 128
) (
  input  logic                          clk,
  input  logic                          rst,
  mcr_in_if.sink                        in_ch,
  mcr_out_if.source                     out_ch,
  input  logic                          cfg_we,
  input  logic [mcr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mcr_pkg::COEF_W-1:0]    cfg_data
);
  localparam int VW = mcr_pkg::VOL_W;
  localparam int SW = mcr_pkg::STORE_W;
  localparam int CW = mcr_pkg::COEF_W;
  localparam int PW = mcr_pkg::PROD_W;
  localparam int HW = mcr_pkg::HI_W;
  localparam int FB = mcr_pkg::COEF_FRAC_BITS;
  localparam int IW = (MAX_REACHES > 1) ? $clog2(MAX_REACHES) : 1;
  localparam int RW0 = $clog2(MAX_REACHES + 1);
  localparam int RCW = (RW0 > mcr_pkg::REACH_REG_W) ? RW0 : mcr_pkg::REACH_REG_W;
  localparam int SW0 = $clog2(MAX_SUBSTEPS + 1);
  localparam int SCW = (SW0 > mcr_pkg::SUB_REG_W) ? SW0 : mcr_pkg::SUB_REG_W;

  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_DIV    = 10'b0000000010,
    S_FETCH  = 10'b0000000100,
    S_LOAD   = 10'b0000001000,
    S_MUL    = 10'b0000010000,
    S_ROUND  = 10'b0000100000,
    S_WR     = 10'b0001000000,
    S_SFETCH = 10'b0010000000,
    S_SADD   = 10'b0100000000,
    S_FINISH = 10'b1000000000
  } state_t;

  // Configuration registers.
  logic [CW-1:0] coef_in_now, coef_in_before, coef_out_before;
  logic [mcr_pkg::SUB_REG_W-1:0] substep_count;
  logic [mcr_pkg::REACH_REG_W-1:0] reach_count;
  logic bypass;

  // Reach stores and their valid bits.
  logic [SW-1:0] stor_mem [MAX_REACHES];
  logic [VW-1:0] pin_mem [MAX_REACHES];
  logic [VW-1:0] pout_mem [MAX_REACHES];
  logic [MAX_REACHES-1:0] stor_valid, prev_valid;
  logic [SW-1:0] rd_stor;
  logic [VW-1:0] rd_pin, rd_pout;
  logic rd_sv, rd_pv;

  // Sequencer and datapath registers.
  state_t state;
  logic [IW-1:0] r;
  logic [SCW-1:0] sub_i;
  logic [VW-1:0] passing, op_p, op_pi, op_po, lo, o_val, tot_out, res_out;
  logic [HW-1:0] hi;
  logic [mcr_pkg::BIT_CNT_W-1:0] mcnt;
  logic [SW:0] cap;
  logic [SW-1:0] acc, res_store;
  logic out_valid;
  logic [VW-1:0] out_vol;
  logic [SW-1:0] out_store;

  // Combinational helpers.
  logic [SCW-1:0] sub_ext, sub_act, last_sub;
  logic [RCW-1:0] reach_ext, reach_act;
  logic [IW-1:0] last_r;
  logic in_fire, div_start, div_done, mem_we;
  logic [VW-1:0] div_q;
  logic [HW-1:0] t_now, t_inb, t_outb;
  logic [HW:0] hi_sum;
  logic signed [PW-1:0] prod;
  logic [PW-1:0] rnd;
  logic [VW-1:0] o_next;
  logic [SW:0] stor_diff;
  logic [SW-1:0] stor_new;
  logic [VW:0] tot_sum;
  logic [SW:0] acc_sum;

  // Active counts with the zero and overflow cases folded in.
  always_comb begin
    sub_ext = SCW'(substep_count);
    if (sub_ext == '0) sub_act = SCW'(1);
    else if (sub_ext > SCW'(MAX_SUBSTEPS)) sub_act = SCW'(MAX_SUBSTEPS);
    else sub_act = sub_ext;
    last_sub = sub_act - SCW'(1);
    reach_ext = RCW'(reach_count);
    if (reach_ext == '0) reach_act = RCW'(1);
    else if (reach_ext > RCW'(MAX_REACHES)) reach_act = RCW'(MAX_REACHES);
    else reach_act = reach_ext;
    last_r = IW'(reach_act - RCW'(1));
  end

  assign in_ch.ready = (state == S_IDLE);
  assign in_fire = in_ch.valid && in_ch.ready;
  assign div_start = in_fire && !bypass;
  assign mem_we = (state == S_WR);

  mcr_divider #(.DEN_W(SCW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (in_ch.inflow_volume),
    .divisor  (sub_act),
    .done     (div_done),
    .quotient (div_q)
  );

  // One serial step: add the coefficients selected by the low operand bits.
  always_comb begin
    t_now = op_p[0] ? {{(HW-CW){coef_in_now[CW-1]}}, coef_in_now} : '0;
    t_inb = op_pi[0] ? {{(HW-CW){coef_in_before[CW-1]}}, coef_in_before} : '0;
    t_outb = op_po[0] ? {{(HW-CW){coef_out_before[CW-1]}}, coef_out_before} : '0;
    hi_sum = {hi[HW-1], hi} + {t_now[HW-1], t_now} + {t_inb[HW-1], t_inb}
           + {t_outb[HW-1], t_outb};
  end

  // Round to nearest, then clamp to stored water plus inflow and to the volume range.
  always_comb begin
    prod = signed'({hi, lo});
    rnd = (PW'(prod) + (PW'(1) << (FB - 1))) >> FB;
    if (prod <= 0) o_next = '0;
    else if (rnd > PW'(cap)) o_next = (cap > (SW+1)'({VW{1'b1}})) ? {VW{1'b1}} : VW'(cap);
    else if (rnd > PW'({VW{1'b1}})) o_next = {VW{1'b1}};
    else o_next = VW'(rnd);
  end

  // Storage balance and saturating sums.
  always_comb begin
    stor_diff = cap - (SW+1)'(o_val);
    stor_new = stor_diff[SW] ? {SW{1'b1}} : stor_diff[SW-1:0];
    tot_sum = (VW+1)'(tot_out) + (VW+1)'(o_val);
    acc_sum = (SW+1)'(acc) + (SW+1)'(rd_sv ? rd_stor : '0);
  end

  // Reach stores: one write and one registered read per cycle at the current reach.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      stor_mem[r] <= stor_new;
      pin_mem[r] <= op_p;
      pout_mem[r] <= o_val;
    end
    rd_stor <= stor_mem[r];
    rd_pin <= pin_mem[r];
    rd_pout <= pout_mem[r];
    rd_sv <= stor_valid[r];
    rd_pv <= prev_valid[r];
  end

  // Configuration writes, valid bits and the routing sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      coef_in_now <= CW'(64'(1) << FB);
      coef_in_before <= '0;
      coef_out_before <= '0;
      substep_count <= mcr_pkg::SUB_REG_W'(1);
      reach_count <= mcr_pkg::REACH_REG_W'(1);
      bypass <= 1'b0;
      stor_valid <= '0;
      prev_valid <= '0;
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          mcr_pkg::CFG_COEF_IN_NOW: coef_in_now <= cfg_data;
          mcr_pkg::CFG_COEF_IN_BEFORE: coef_in_before <= cfg_data;
          mcr_pkg::CFG_COEF_OUT_BEFORE: coef_out_before <= cfg_data;
          mcr_pkg::CFG_SUBSTEP_COUNT: begin
            substep_count <= cfg_data[mcr_pkg::SUB_REG_W-1:0];
            prev_valid <= '0;
          end
          mcr_pkg::CFG_REACH_COUNT: reach_count <= cfg_data[mcr_pkg::REACH_REG_W-1:0];
          mcr_pkg::CFG_BYPASS: bypass <= cfg_data[0];
          default: ;
        endcase
      end
      // The finish state loads a new result itself; elsewhere a taken result is dropped.
      if (out_ch.ready && state != S_FINISH) out_valid <= 1'b0;

      case (state)
        S_IDLE: begin
          if (in_fire) begin
            if (bypass) begin
              stor_valid <= '0;
              res_out <= in_ch.inflow_volume;
              res_store <= '0;
              state <= S_FINISH;
            end else begin
              sub_i <= '0;
              tot_out <= '0;
              state <= S_DIV;
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            passing <= div_q;
            r <= '0;
            state <= S_FETCH;
          end
        end
        S_FETCH: state <= S_LOAD;
        S_LOAD: begin
          op_p <= passing;
          op_pi <= rd_pv ? rd_pin : '0;
          op_po <= rd_pv ? rd_pout : '0;
          cap <= (SW+1)'(rd_sv ? rd_stor : '0) + (SW+1)'(passing);
          hi <= '0;
          mcnt <= '0;
          state <= S_MUL;
        end
        S_MUL: begin
          // Product bits leave the accumulator at the bottom, one per cycle.
          lo <= {hi_sum[0], lo[VW-1:1]};
          hi <= hi_sum[HW:1];
          op_pi <= op_pi >> 1;
          op_po <= op_po >> 1;
          op_p <= {op_p[0], op_p[VW-1:1]};
          mcnt <= mcnt + 1'b1;
          if (mcnt == mcr_pkg::BIT_CNT_W'(VW - 1)) state <= S_ROUND;
        end
        S_ROUND: begin
          o_val <= o_next;
          state <= S_WR;
        end
        S_WR: begin
          stor_valid[r] <= 1'b1;
          prev_valid[r] <= 1'b1;
          if (r == last_r) begin
            tot_out <= tot_sum[VW] ? {VW{1'b1}} : tot_sum[VW-1:0];
            r <= '0;
            if (sub_i == last_sub) begin
              acc <= '0;
              state <= S_SFETCH;
            end else begin
              sub_i <= sub_i + 1'b1;
              passing <= div_q;
              state <= S_FETCH;
            end
          end else begin
            passing <= o_val;
            r <= r + 1'b1;
            state <= S_FETCH;
          end
        end
        S_SFETCH: state <= S_SADD;
        S_SADD: begin
          acc <= acc_sum[SW] ? {SW{1'b1}} : acc_sum[SW-1:0];
          if (r == last_r) begin
            res_out <= tot_out;
            res_store <= acc_sum[SW] ? {SW{1'b1}} : acc_sum[SW-1:0];
            state <= S_FINISH;
          end else begin
            r <= r + 1'b1;
            state <= S_SFETCH;
          end
        end
        S_FINISH: begin
          if (!out_valid || out_ch.ready) begin
            out_valid <= 1'b1;
            out_vol <= res_out;
            out_store <= res_store;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid = out_valid;
  assign out_ch.outflow_volume = out_vol;
  assign out_ch.total_storage = out_store;

  `include "assert_macros.svh"
  `MCR_ASSERT(a_out_within_cap, state == S_WR, (SW+1)'(o_val) <= cap)
  `MCR_ASSERT(a_reach_in_range, state == S_FETCH || state == S_SFETCH, r <= last_r)
  `MCR_ASSERT_NEXT(a_bypass_result, in_fire && bypass, state == S_FINISH && res_store == '0)
endmodule
`default_nettype wire
